// ===== design/sobel_edge_magnitude_rgb_core_assert.svh =====
// Assertion macros shared by the Sobel edge core.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_CORE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SOBEL_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SOBEL_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

// ===== design/sobel_pkg.sv =====
// Shared types and constants of the Sobel edge core.
`default_nettype none
package sobel_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int CLAMP_MAX     = 255;
  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;
  localparam int SQRT_STEPS    = 11;
  localparam int SUM_W         = 2 * SQRT_STEPS;

  // Configuration register indexes
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_GRAD,
    ST_SQR,
    ST_ROOT,
    ST_FIN,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic update;
    logic grad;
    logic square;
    logic root_step;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit;
    logic at_origin;
  } status_t;

endpackage
`default_nettype wire

// ===== design/sobel_px_if.sv =====
// Input pixel channel.
`default_nettype none
interface sobel_px_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       drain;
  modport source (output valid, pixel_red, pixel_green, pixel_blue, drain, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, drain, output ready);
endinterface
`default_nettype wire

// ===== design/sobel_edge_if.sv =====
// Result edge channel.
`default_nettype none
interface sobel_edge_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_red;
  logic [7:0] edge_green;
  logic [7:0] edge_blue;
  logic       frame_end;
  modport source (output valid, edge_red, edge_green, edge_blue, frame_end, input ready);
  modport sink   (input valid, edge_red, edge_green, edge_blue, frame_end, output ready);
endinterface
`default_nettype wire

// ===== design/sobel_cfg_if.sv =====
// Configuration write channel.
`default_nettype none
interface sobel_cfg_if;
  logic        valid;
  logic        ready;
  logic        addr;
  logic [12:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ===== design/sobel_edge_magnitude_rgb_core.sv =====
// Sobel edge magnitude core: top level joining controller and datapath.
// Sequence: capture in IDLE, window update in LOAD; an item with a result then runs GRAD, SQR,
// the 11-step bit-serial square root in ROOT (three channels in parallel), FIN and OUT.
// A new item is taken only once the last one is done and its result, if any, is taken.
// Reset (rst_n low, synchronous) restores 640x480, clears window and frame counters.
// Line stores are not cleared; never-written entries fall outside the frame mask.
`default_nettype none
module sobel_edge_magnitude_rgb_core #(
  parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
  input wire logic     clk,
  input wire logic     rst_n,
  sobel_px_if.sink     in_px,
  sobel_edge_if.source out_px,
  sobel_cfg_if.sink    cfg_wr
);

  `include "sobel_edge_magnitude_rgb_core_assert.svh"

  sobel_pkg::cmd_t    cmd;
  sobel_pkg::status_t st;
  logic in_ready, out_valid;

  // Configuration is always taken
  assign cfg_wr.ready = 1'b1;
  assign in_px.ready  = in_ready;
  assign out_px.valid = out_valid;

  sobel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_px.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_px.ready),
    .st        (st),
    .cmd       (cmd)
  );

  sobel_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .pixel_red   (in_px.pixel_red),
    .pixel_green (in_px.pixel_green),
    .pixel_blue  (in_px.pixel_blue),
    .drain       (in_px.drain),
    .cfg_we      (cfg_wr.valid),
    .cfg_addr    (cfg_wr.addr),
    .cfg_data    (cfg_wr.data),
    .edge_red    (out_px.edge_red),
    .edge_green  (out_px.edge_green),
    .edge_blue   (out_px.edge_blue),
    .frame_end   (out_px.frame_end)
  );

  // One transaction in flight at a time
  `SOBEL_ASSERT_IMP(a_no_overlap, out_valid, !in_ready, "input open while result pending")
  `SOBEL_ASSERT_NXT(a_busy_after_accept, in_px.valid && in_ready, !in_ready,
                    "input still open after accept")
  // Counters are back at frame start while the frame's final result waits
  `SOBEL_ASSERT_IMP(a_frame_restart, out_valid && out_px.frame_end, st.at_origin,
                    "frame counters not restarted at frame end")

endmodule
`default_nettype wire

// ===== design/sobel_ctrl.sv =====
// Sequencing state machine of the Sobel edge core.
`default_nettype none
module sobel_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire sobel_pkg::status_t st,
  output sobel_pkg::cmd_t        cmd
);

  localparam int SW = $clog2(sobel_pkg::SQRT_STEPS);

  sobel_pkg::state_t state_r, state_nxt;
  logic [SW-1:0]     step_r, step_nxt;

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sobel_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      sobel_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sobel_pkg::ST_LOAD;
        end
      end
      sobel_pkg::ST_LOAD: begin
        cmd.update = 1'b1;
        state_nxt  = st.emit ? sobel_pkg::ST_GRAD : sobel_pkg::ST_IDLE;
      end
      sobel_pkg::ST_GRAD: begin
        cmd.grad  = 1'b1;
        state_nxt = sobel_pkg::ST_SQR;
      end
      sobel_pkg::ST_SQR: begin
        cmd.square = 1'b1;
        step_nxt   = '0;
        state_nxt  = sobel_pkg::ST_ROOT;
      end
      sobel_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (step_r == SW'(sobel_pkg::SQRT_STEPS - 1)) begin
          state_nxt = sobel_pkg::ST_FIN;
        end
      end
      sobel_pkg::ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = sobel_pkg::ST_OUT;
      end
      sobel_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = sobel_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sobel_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/sobel_dp.sv =====
// Datapath: line stores, window, frame counters, gradients and square root.
`default_nettype none
module sobel_dp #(
  parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire sobel_pkg::cmd_t cmd,
  output sobel_pkg::status_t   st,
  input  wire logic [7:0]      pixel_red,
  input  wire logic [7:0]      pixel_green,
  input  wire logic [7:0]      pixel_blue,
  input  wire logic            drain,
  input  wire logic            cfg_we,
  input  wire logic            cfg_addr,
  input  wire logic [12:0]     cfg_data,
  output logic [7:0]           edge_red,
  output logic [7:0]           edge_green,
  output logic [7:0]           edge_blue,
  output logic                 frame_end
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int SW = sobel_pkg::SUM_W;
  localparam int RW = sobel_pkg::SQRT_STEPS;

  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [WW-1:0] eff_w;
  logic [12:0]   eff_h;

  logic [CW-1:0] in_col_r;
  logic [12:0]   in_row_r;
  logic [CW-1:0] oc_col_r;
  logic [11:0]   oc_row_r;

  logic [23:0] mid_mem [MAX_WIDTH];
  logic [23:0] top_mem [MAX_WIDTH];
  logic [23:0] rd_mid_r, rd_top_r;
  logic [23:0] x_r;
  logic [23:0] win_r [9];

  logic mtop_r, mbot_r, mleft_r, mright_r, last_r;
  logic in_wrap, oc_wrap, last_now;

  logic signed [10:0] gx_r [3];
  logic signed [10:0] gy_r [3];
  logic [SW-1:0] rad_r  [3];
  logic [RW+1:0] rem_r  [3];
  logic [RW-1:0] root_r [3];

  // Saturated frame size
  always_comb begin
    if (width_r == 11'd0) begin
      eff_w = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end
    if (height_r == 13'd0) begin
      eff_h = 13'd1;
    end else if (32'(height_r) > 32'(sobel_pkg::MAX_HEIGHT)) begin
      eff_h = 13'(sobel_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  // Frame position status
  assign st = '{emit:      (in_row_r >= 13'd2) || (in_row_r == 13'd1 && in_col_r != '0),
                at_origin: (in_col_r == '0) && (in_row_r == 13'd0) &&
                           (oc_col_r == '0) && (oc_row_r == 12'd0)};
  assign in_wrap  = (WW'(in_col_r) + WW'(1)) == eff_w;
  assign oc_wrap  = (WW'(oc_col_r) + WW'(1)) == eff_w;
  assign last_now = st.emit && oc_wrap && (13'(oc_row_r) == eff_h - 13'd1);

  // Configuration registers and stream counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'(sobel_pkg::RESET_WIDTH);
      height_r <= 13'(sobel_pkg::RESET_HEIGHT);
      in_col_r <= '0;
      in_row_r <= '0;
      oc_col_r <= '0;
      oc_row_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sobel_pkg::REG_FRAME_WIDTH:  width_r  <= cfg_data[10:0];
        sobel_pkg::REG_FRAME_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
      in_col_r <= '0;
      in_row_r <= '0;
      oc_col_r <= '0;
      oc_row_r <= '0;
    end else if (cmd.update) begin
      if (last_now) begin
        in_col_r <= '0;
        in_row_r <= '0;
        oc_col_r <= '0;
        oc_row_r <= '0;
      end else begin
        if (in_wrap) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + 13'd1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
        if (st.emit) begin
          if (oc_wrap) begin
            oc_col_r <= '0;
            oc_row_r <= oc_row_r + 12'd1;
          end else begin
            oc_col_r <= oc_col_r + 1'b1;
          end
        end
      end
    end
  end

  // Pixel capture; drains and pixels past the frame enter as zero
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      if (!drain && in_row_r < eff_h) begin
        x_r <= {pixel_blue, pixel_green, pixel_red};
      end else begin
        x_r <= '0;
      end
    end
  end

  // Line stores: read every cycle, write on update
  always_ff @(posedge clk) begin
    rd_mid_r <= mid_mem[in_col_r];
    rd_top_r <= top_mem[in_col_r];
    if (cmd.update) begin
      mid_mem[in_col_r] <= x_r;
      top_mem[in_col_r] <= rd_mid_r;
    end
  end

  // Window shift and border masks of the output position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.update) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]   <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= rd_top_r;
      win_r[5] <= rd_mid_r;
      win_r[8] <= x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      mtop_r   <= oc_row_r != 12'd0;
      mbot_r   <= 13'(oc_row_r) != eff_h - 13'd1;
      mleft_r  <= oc_col_r != '0;
      mright_r <= !oc_wrap;
      last_r   <= last_now;
    end
  end

  // Gradients, squares and square root per channel
  always_ff @(posedge clk) begin
    logic signed [11:0] v [9];
    logic [RW+1:0] sh;
    logic [RW+1:0] trial;
    logic signed [SW-1:0] gxe, gye;
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        if (((k / 3 == 0) && !mtop_r) || ((k / 3 == 2) && !mbot_r) ||
            ((k % 3 == 0) && !mleft_r) || ((k % 3 == 2) && !mright_r)) begin
          v[k] = '0;
        end else begin
          v[k] = $signed({4'd0, win_r[k][ch*8 +: 8]});
        end
      end
      if (cmd.grad) begin
        gx_r[ch] <= 11'((v[6] + 12'sd2 * v[7] + v[8]) - (v[0] + 12'sd2 * v[1] + v[2]));
        gy_r[ch] <= 11'((v[2] + 12'sd2 * v[5] + v[8]) - (v[0] + 12'sd2 * v[3] + v[6]));
      end
      if (cmd.square) begin
        // sign-extend before squaring so the products keep their full width
        gxe = SW'(gx_r[ch]);
        gye = SW'(gy_r[ch]);
        rad_r[ch]  <= $unsigned(gxe * gxe) + $unsigned(gye * gye);
        rem_r[ch]  <= '0;
        root_r[ch] <= '0;
      end
      if (cmd.root_step) begin
        sh    = {rem_r[ch][RW-1:0], rad_r[ch][SW-1 -: 2]};
        trial = {root_r[ch], 2'b01};
        rad_r[ch] <= {rad_r[ch][SW-3:0], 2'b00};
        if (sh >= trial) begin
          rem_r[ch]  <= sh - trial;
          root_r[ch] <= {root_r[ch][RW-2:0], 1'b1};
        end else begin
          rem_r[ch]  <= sh;
          root_r[ch] <= {root_r[ch][RW-2:0], 1'b0};
        end
      end
    end
  end

  // Rounding, clamping and result register
  always_ff @(posedge clk) begin
    logic [RW:0] n [3];
    logic [7:0]  e [3];
    for (int ch = 0; ch < 3; ch++) begin
      n[ch] = {1'b0, root_r[ch]} + ((rem_r[ch] > (RW+2)'(root_r[ch])) ? (RW+1)'(1) : '0);
      e[ch] = (32'(n[ch]) > sobel_pkg::CLAMP_MAX) ? 8'(sobel_pkg::CLAMP_MAX) : n[ch][7:0];
    end
    if (cmd.finish) begin
      edge_red   <= e[0];
      edge_green <= e[1];
      edge_blue  <= e[2];
      frame_end  <= last_r;
    end
  end

endmodule
`default_nettype wire
